// ===== hw/rtl/diag_service_access_gate_core_defines.svh =====
// Assertion macros for the diagnostic service access gate.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef DIAG_SERVICE_ACCESS_GATE_CORE_DEFINES_SVH
`define DIAG_SERVICE_ACCESS_GATE_CORE_DEFINES_SVH

// Same-cycle implication.
`define DSAG_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DSAG_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dsag_pkg.sv =====
// Types, codes and the service table of the diagnostic service access gate.
// No dependencies; used by the channel interfaces and the top level.
package dsag_pkg;

	localparam int SVC_COUNT   = 12;
	localparam int SVC_IDX_W   = 4;
	localparam int SID_W       = 8;
	localparam int TICK_W      = 8;
	localparam int TIMER_W     = 16;
	localparam int ATTEMPT_W   = 8;
	localparam int ACC_COLS    = 6;
	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd5000;

	typedef enum logic [1:0] {
		REQ_SERVICE = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_UPDATE  = 2'd2,
		REQ_INIT    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		VERDICT_FORWARD = 2'd0,
		VERDICT_NEGATIVE = 2'd1,
		VERDICT_DROP    = 2'd2,
		VERDICT_NONE    = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		NEG_NONE        = 2'd0,
		NEG_UNSUPPORTED = 2'd1,
		NEG_SESSION     = 2'd2,
		NEG_SECURITY    = 2'd3
	} neg_t;

	typedef enum logic [1:0] {
		SESS_DEFAULT  = 2'd0,
		SESS_PROGRAM  = 2'd1,
		SESS_EXTENDED = 2'd2
	} session_t;

	typedef enum logic [1:0] {
		ACC_NONE   = 2'd0,
		ACC_NORMAL = 2'd1,
		ACC_SECURE = 2'd2
	} acc_t;

	localparam logic [SID_W-1:0] SVC_SID [SVC_COUNT] = '{
		8'h10, 8'h11, 8'h22, 8'h27, 8'h28, 8'h2E,
		8'h31, 8'h34, 8'h36, 8'h37, 8'h3E, 8'h85
	};

	// Columns: functional default/program/extended, physical default/program/extended.
	localparam acc_t SVC_ACC [SVC_COUNT][ACC_COLS] = '{
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NORMAL, ACC_NONE,   ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NORMAL, ACC_NONE},
		'{ACC_NORMAL, ACC_NONE,   ACC_NORMAL, ACC_NONE,   ACC_NONE,   ACC_NORMAL},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_SECURE},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_NONE},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_NONE},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_NONE},
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NONE,   ACC_NONE,   ACC_NORMAL}
	};

	function automatic acc_t svc_access(
		input logic [SVC_IDX_W-1:0] idx,
		input logic                 functional,
		input session_t             sess
	);
		logic [2:0] col;
		col = functional ? {1'b0, sess} : (3'd3 + {1'b0, sess});
		if ((idx >= SVC_IDX_W'(SVC_COUNT)) || (sess == SESS_DEFAULT && 1'b0) ||
		    (sess != SESS_DEFAULT && sess != SESS_PROGRAM && sess != SESS_EXTENDED))
			return ACC_NONE;
		return SVC_ACC[idx][col];
	endfunction

endpackage

// ===== hw/rtl/dsag_if.sv =====
// Channel interfaces of the diagnostic service access gate: request items,
// result items and the session timeout write port. Depends on dsag_pkg.
interface dsag_req_if;
	import dsag_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [SID_W-1:0]     service_id;
	logic                 functional_addr;
	logic [TICK_W-1:0]    time_pass;
	logic [1:0]           new_session;
	logic                 new_security;
	logic [TIMER_W-1:0]   new_attempt_delay;
	logic [ATTEMPT_W-1:0] new_attempts;
	logic                 boot_flag;
	logic                 unlock_flag;

	modport source (
		output valid, req_type, service_id, functional_addr, time_pass, new_session,
		       new_security, new_attempt_delay, new_attempts, boot_flag, unlock_flag,
		input  ready
	);
	modport sink (
		input  valid, req_type, service_id, functional_addr, time_pass, new_session,
		       new_security, new_attempt_delay, new_attempts, boot_flag, unlock_flag,
		output ready
	);
endinterface

interface dsag_rsp_if;
	import dsag_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           verdict;
	logic [1:0]           neg_code;
	logic [SVC_IDX_W-1:0] service_index;
	logic [SID_W-1:0]     echo_sid;
	logic                 timeout_event;
	logic                 system_reset;
	logic [1:0]           cur_session;
	logic                 cur_security;
	logic [ATTEMPT_W-1:0] cur_attempts;

	modport source (
		output valid, verdict, neg_code, service_index, echo_sid, timeout_event,
		       system_reset, cur_session, cur_security, cur_attempts,
		input  ready
	);
	modport sink (
		input  valid, verdict, neg_code, service_index, echo_sid, timeout_event,
		       system_reset, cur_session, cur_security, cur_attempts,
		output ready
	);
endinterface

interface dsag_cfg_if;
	import dsag_pkg::*;
	logic               valid;
	logic               ready;
	logic [TIMER_W-1:0] session_timeout;

	modport source (output valid, session_timeout, input ready);
	modport sink (input valid, session_timeout, output ready);
endinterface

// ===== hw/rtl/diag_service_access_gate_core.sv =====
// Diagnostic service access gate, top level.
// Depends on dsag_pkg, the dsag_*_if interfaces and the assertion macro header.

// Takes one request every clock cycle unless the result side stalls, and
// returns exactly one result for it: the item
// is captured in an input register, then the service table match, the access
// check, the idle timer and the attempt delay countdown all resolve in one
// pass of logic into the result register while the session state updates.
// While a result waits to be taken the input register still takes one request,
// so a stalled sink costs one buffered request before req.ready drops. The user
// must write the session timeout register through cfg only while the block is
// idle; the block does not check this. It resets to 5000 and a value of zero behaves as one tick.
module diag_service_access_gate_core (
	input  logic               clk,
	input  logic               arst_n,
	dsag_cfg_if.sink           cfg,
	dsag_req_if.sink           req,
	dsag_rsp_if.source         rsp
);
	import dsag_pkg::*;

	`include "diag_service_access_gate_core_defines.svh"

	// Input stage.
	logic                 valid_s1;
	logic [1:0]           type_s1;
	logic [SID_W-1:0]     sid_s1;
	logic                 func_s1;
	logic [TICK_W-1:0]    tp_s1;
	logic [1:0]           new_sess_s1;
	logic                 new_sec_s1;
	logic [TIMER_W-1:0]   new_delay_s1;
	logic [ATTEMPT_W-1:0] new_att_s1;
	logic                 boot_s1;
	logic                 unlock_s1;

	// Session state. Routine unlock and last addressing kind never reach a
	// result, so they are not kept.
	logic [TIMER_W-1:0]   timeout_q;
	session_t             session_q, session_d;
	logic                 active_q, active_d;
	logic [TIMER_W-1:0]   idle_q, idle_d;
	logic                 security_q, security_d;
	logic [TIMER_W-1:0]   delay_q, delay_d;
	logic [ATTEMPT_W-1:0] attempts_q, attempts_d;

	// Result register.
	logic                 rsp_valid_q;
	verdict_t             verdict_q, verdict_d;
	neg_t                 neg_q, neg_d;
	logic [SVC_IDX_W-1:0] sidx_q, sidx_d;
	logic [SID_W-1:0]     echo_q, echo_d;
	logic                 tevt_q, tevt_d;
	logic                 sreset_q, sreset_d;

	logic                 advance;
	logic                 load;

	// Combinational helpers.
	logic                 found;
	logic [SVC_IDX_W-1:0] match_idx;
	acc_t                 acc;
	logic [TIMER_W:0]     idle_sum;
	logic [TIMER_W-1:0]   idle_acc;
	logic [TIMER_W-1:0]   limit;
	logic [TIMER_W-1:0]   tp_wide;
	logic [TIMER_W-1:0]   delay_rem;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign load      = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.session_timeout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			type_s1      <= req.req_type;
			sid_s1       <= req.service_id;
			func_s1      <= req.functional_addr;
			tp_s1        <= req.time_pass;
			new_sess_s1  <= req.new_session;
			new_sec_s1   <= req.new_security;
			new_delay_s1 <= req.new_attempt_delay;
			new_att_s1   <= req.new_attempts;
			boot_s1      <= req.boot_flag;
			unlock_s1    <= req.unlock_flag;
		end
	end

	// Service table match; the identifiers are distinct, lowest index wins.
	always_comb begin
		found     = 1'b0;
		match_idx = '0;
		for (int i = SVC_COUNT - 1; i >= 0; i--) begin
			if (SVC_SID[i] == sid_s1) begin
				found     = 1'b1;
				match_idx = SVC_IDX_W'(i);
			end
		end
	end

	assign acc       = svc_access(match_idx, func_s1, session_q);
	assign tp_wide   = {{(TIMER_W-TICK_W){1'b0}}, tp_s1};
	assign idle_sum  = {1'b0, idle_q} + {1'b0, tp_wide};
	assign limit     = (timeout_q == '0) ? TIMER_W'(1) : timeout_q;
	assign delay_rem = delay_q - tp_wide;

	always_comb begin
		session_d  = session_q;
		active_d   = active_q;
		idle_d     = idle_q;
		security_d = security_q;
		delay_d    = delay_q;
		attempts_d = attempts_q;
		verdict_d  = VERDICT_NONE;
		neg_d      = NEG_NONE;
		sidx_d     = '0;
		echo_d     = '0;
		tevt_d     = 1'b0;
		sreset_d   = 1'b0;
		idle_acc   = idle_q;

		unique case (req_kind_t'(type_s1))
			REQ_SERVICE: begin
				active_d = 1'b1;
				idle_d   = '0;
				if (!found) begin
					if (func_s1) begin
						verdict_d = VERDICT_DROP;
					end else begin
						verdict_d = VERDICT_NEGATIVE;
						neg_d     = NEG_UNSUPPORTED;
						echo_d    = sid_s1;
					end
				end else begin
					echo_d = sid_s1;
					priority if (acc == ACC_NONE) begin
						verdict_d = VERDICT_NEGATIVE;
						neg_d     = NEG_SESSION;
					end else if (acc == ACC_SECURE && !security_q) begin
						verdict_d = VERDICT_NEGATIVE;
						neg_d     = NEG_SECURITY;
					end else begin
						verdict_d = VERDICT_FORWARD;
						sidx_d    = match_idx;
					end
				end
			end
			REQ_TICK: begin
				// Saturate the idle count; it only runs in an active non-default session.
				if (active_q && session_q != SESS_DEFAULT) begin
					idle_acc = idle_sum[TIMER_W] ? '1 : idle_sum[TIMER_W-1:0];
				end
				idle_d = idle_acc;
				if (idle_acc >= limit) begin
					tevt_d     = 1'b1;
					sreset_d   = (session_q == SESS_PROGRAM);
					active_d   = 1'b0;
					idle_d     = '0;
					security_d = 1'b0;
					session_d  = SESS_DEFAULT;
				end
				if (delay_q >= tp_wide) begin
					if (delay_rem < tp_wide) begin
						delay_d = '0;
						if (attempts_q != '0) begin
							attempts_d = attempts_q - ATTEMPT_W'(1);
						end
					end else begin
						delay_d = delay_rem;
					end
				end else begin
					delay_d = '0;
				end
			end
			REQ_UPDATE: begin
				// Session code three leaves the session alone.
				if (new_sess_s1 != 2'd3) begin
					session_d = session_t'(new_sess_s1);
				end
				security_d = new_sec_s1;
				delay_d    = new_delay_s1;
				attempts_d = new_att_s1;
			end
			REQ_INIT: begin
				session_d  = SESS_DEFAULT;
				active_d   = 1'b0;
				idle_d     = '0;
				security_d = 1'b0;
				delay_d    = '0;
				attempts_d = '0;
				if (boot_s1 || unlock_s1) begin
					active_d  = 1'b1;
					session_d = SESS_PROGRAM;
				end
				if (unlock_s1) begin
					security_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q  <= SESS_DEFAULT;
			active_q   <= 1'b0;
			idle_q     <= '0;
			security_q <= 1'b0;
			delay_q    <= '0;
			attempts_q <= '0;
		end else if (advance) begin
			session_q  <= session_d;
			active_q   <= active_d;
			idle_q     <= idle_d;
			security_q <= security_d;
			delay_q    <= delay_d;
			attempts_q <= attempts_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= verdict_d;
			neg_q     <= neg_d;
			sidx_q    <= sidx_d;
			echo_q    <= echo_d;
			tevt_q    <= tevt_d;
			sreset_q  <= sreset_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.verdict       = verdict_q;
	assign rsp.neg_code      = neg_q;
	assign rsp.service_index = sidx_q;
	assign rsp.echo_sid      = echo_q;
	assign rsp.timeout_event = tevt_q;
	assign rsp.system_reset  = sreset_q;
	assign rsp.cur_session   = session_q;
	assign rsp.cur_security  = security_q;
	assign rsp.cur_attempts  = attempts_q;

	`DSAG_ASSERT_IMP(a_reset_needs_timeout, rsp.valid && rsp.system_reset, rsp.timeout_event, "system reset without timeout")
	`DSAG_ASSERT_IMP(a_timeout_default, rsp.valid && rsp.timeout_event, rsp.cur_session == SESS_DEFAULT && !rsp.cur_security, "session not closed on timeout")
	`DSAG_ASSERT_IMP(a_forward_clean, rsp.valid && rsp.verdict == VERDICT_FORWARD, rsp.neg_code == NEG_NONE && rsp.service_index < SVC_IDX_W'(SVC_COUNT), "forwarded request carries a bad code or index")
	`DSAG_ASSERT_NEXT(a_stage_holds, valid_s1 && !advance, valid_s1, "buffered request lost")

endmodule

// ===== dv/diag_service_access_gate_core_tb.sv =====
// Testbench for diag_service_access_gate_core: directed and random request
// streams, checked field by field against an in-bench session/access model.
// Depends on dsag_pkg, the dsag_*_if interfaces and the gate RTL.
module diag_service_access_gate_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dsag_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam logic [1:0] SESS_KEEP = 2'd3;

	typedef struct packed {
		req_kind_t  kind;
		logic [7:0]  sid;
		logic        func;
		logic [7:0]  tp;
		logic [1:0]  nsess;
		logic        nsec;
		logic [15:0] ndelay;
		logic [7:0]  natt;
		logic        boot;
		logic        unl;
	} gate_req_t;

	typedef struct packed {
		verdict_t   verdict;
		neg_t       neg;
		logic [3:0] idx;
		logic [7:0] echo;
		logic       tevt;
		logic       sreset;
		logic [1:0] sess;
		logic       sec;
		logic [7:0] att;
	} gate_rsp_t;

	localparam logic [7:0] KNOWN_SID [12] = '{
		8'h10, 8'h11, 8'h22, 8'h27, 8'h28, 8'h2E,
		8'h31, 8'h34, 8'h36, 8'h37, 8'h3E, 8'h85
	};

	// functional default/program/extended, then physical default/program/extended
	localparam acc_t USE_TBL [12][6] = '{
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NORMAL, ACC_NONE,   ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NORMAL, ACC_NONE},
		'{ACC_NORMAL, ACC_NONE,   ACC_NORMAL, ACC_NONE,   ACC_NONE,   ACC_NORMAL},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_SECURE},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_NONE},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_NONE},
		'{ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_NONE,   ACC_SECURE, ACC_NONE},
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NORMAL},
		'{ACC_NORMAL, ACC_NORMAL, ACC_NORMAL, ACC_NONE,   ACC_NONE,   ACC_NORMAL}
	};

	logic clk;
	logic arst_n;

	dsag_cfg_if cfg_ch();
	dsag_req_if req_ch();
	dsag_rsp_if rsp_ch();

	diag_service_access_gate_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// session state as the gate should hold it
	session_t    sess_now;
	logic        active_now;
	int          idle_now;
	logic        sec_now;
	logic        routine_now;
	logic        addr_now;
	int          delay_now;
	logic [7:0]  tries_now;
	logic [15:0] timeout_setting;

	gate_rsp_t pending_verdicts [$];
	gate_rsp_t want;
	int        mismatches;
	int        items_sent;
	int        cycle_count;
	int        long_hold;
	int        hold_left;
	bit        src_calm;
	bit        sink_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic gate_rsp_t gate_decide(input gate_req_t it);
		gate_rsp_t o;
		int        hit;
		int        i;
		int        col;
		int        lim;
		acc_t      use_kind;
		o = '0;
		o.verdict = VERDICT_NONE;
		o.neg = NEG_NONE;
		case (it.kind)
			REQ_SERVICE: begin
				addr_now = it.func;
				active_now = 1'b1;
				idle_now = 0;
				hit = -1;
				for (i = 0; i < 12; i++)
					if (hit < 0 && KNOWN_SID[i] == it.sid)
						hit = i;
				if (hit < 0) begin
					if (it.func) begin
						o.verdict = VERDICT_DROP;
					end else begin
						o.verdict = VERDICT_NEGATIVE;
						o.neg = NEG_UNSUPPORTED;
						o.echo = it.sid;
					end
				end else begin
					o.echo = it.sid;
					col = (it.func ? 0 : 3) + int'(sess_now);
					use_kind = USE_TBL[hit][col];
					if (use_kind == ACC_NONE) begin
						o.verdict = VERDICT_NEGATIVE;
						o.neg = NEG_SESSION;
					end else if (use_kind == ACC_SECURE && !sec_now) begin
						o.verdict = VERDICT_NEGATIVE;
						o.neg = NEG_SECURITY;
					end else begin
						o.verdict = VERDICT_FORWARD;
						o.idx = 4'(hit);
					end
				end
			end
			REQ_TICK: begin
				lim = (timeout_setting == 16'd0) ? 1 : int'(timeout_setting);
				if (active_now && sess_now != SESS_DEFAULT) begin
					idle_now += int'(it.tp);
					if (idle_now > 65535)
						idle_now = 65535;
				end
				// stored idle count is compared even in default session
				if (idle_now >= lim) begin
					o.tevt = 1'b1;
					o.sreset = (sess_now == SESS_PROGRAM);
					active_now = 1'b0;
					idle_now = 0;
					routine_now = 1'b0;
					sec_now = 1'b0;
					sess_now = SESS_DEFAULT;
				end
				if (delay_now >= int'(it.tp)) begin
					delay_now -= int'(it.tp);
					if (delay_now < int'(it.tp)) begin
						delay_now = 0;
						if (tries_now != 8'd0)
							tries_now--;
					end
				end else begin
					delay_now = 0;
				end
			end
			REQ_UPDATE: begin
				if (it.nsess != SESS_KEEP)
					sess_now = session_t'(it.nsess);
				sec_now = it.nsec;
				delay_now = int'(it.ndelay);
				tries_now = it.natt;
			end
			default: begin
				sess_now = SESS_DEFAULT;
				active_now = 1'b0;
				idle_now = 0;
				sec_now = 1'b0;
				routine_now = 1'b0;
				delay_now = 0;
				tries_now = 8'd0;
				addr_now = 1'b0;
				if (it.boot || it.unl) begin
					active_now = 1'b1;
					sess_now = SESS_PROGRAM;
				end
				if (it.unl) begin
					sec_now = 1'b1;
					routine_now = 1'b1;
				end
			end
		endcase
		o.sess = sess_now;
		o.sec = sec_now;
		o.att = tries_now;
		return o;
	endfunction

	function automatic gate_req_t rand_item();
		gate_req_t it;
		it.kind = req_kind_t'($urandom_range(0, 3));
		it.sid = 8'($urandom_range(0, 255));
		it.func = 1'($urandom_range(0, 1));
		it.tp = 8'($urandom_range(0, 255));
		it.nsess = 2'($urandom_range(0, 3));
		it.nsec = 1'($urandom_range(0, 1));
		it.ndelay = 16'($urandom_range(0, 65535));
		it.natt = 8'($urandom_range(0, 255));
		it.boot = 1'($urandom_range(0, 1));
		it.unl = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic gate_req_t mk_req(input logic [7:0] sid, input logic func);
		gate_req_t it;
		it = rand_item();
		it.kind = REQ_SERVICE;
		it.sid = sid;
		it.func = func;
		return it;
	endfunction

	function automatic gate_req_t mk_tick(input logic [7:0] tp);
		gate_req_t it;
		it = rand_item();
		it.kind = REQ_TICK;
		it.tp = tp;
		return it;
	endfunction

	function automatic gate_req_t mk_update(input logic [1:0] sess, input logic sec,
			input logic [15:0] delay, input logic [7:0] att);
		gate_req_t it;
		it = rand_item();
		it.kind = REQ_UPDATE;
		it.nsess = sess;
		it.nsec = sec;
		it.ndelay = delay;
		it.natt = att;
		return it;
	endfunction

	function automatic gate_req_t mk_init(input logic boot, input logic unl);
		gate_req_t it;
		it = rand_item();
		it.kind = REQ_INIT;
		it.boot = boot;
		it.unl = unl;
		return it;
	endfunction

	function automatic logic [7:0] pick_sid();
		if ($urandom_range(0, 99) < 75)
			return KNOWN_SID[$urandom_range(0, 11)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_gap();
		int r;
		if (src_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input gate_req_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.req_type = it.kind;
		req_ch.service_id = it.sid;
		req_ch.functional_addr = it.func;
		req_ch.time_pass = it.tp;
		req_ch.new_session = it.nsess;
		req_ch.new_security = it.nsec;
		req_ch.new_attempt_delay = it.ndelay;
		req_ch.new_attempts = it.natt;
		req_ch.boot_flag = it.boot;
		req_ch.unlock_flag = it.unl;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		pending_verdicts.push_back(gate_decide(it));
		items_sent++;
	endtask

	// drop valid and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		drain();
		@(negedge clk);
		cfg_ch.session_timeout = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		timeout_setting = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic run_random(input int count);
		int stop;
		int r;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				// enter a session, then exercise it with requests
				if ($urandom_range(0, 1))
					send_item(mk_init(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				else
					send_item(mk_update(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						16'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 300)
							: $urandom_range(0, 65535)),
						8'($urandom_range(0, 255))));
				repeat ($urandom_range(2, 8))
					send_item(mk_req(pick_sid(), 1'($urandom_range(0, 1))));
			end else if (r < 37) begin
				repeat ($urandom_range(2, 10))
					send_item(mk_tick(8'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 40)
						: $urandom_range(0, 255))));
			end else if (r < 85) begin
				send_item(mk_req(pick_sid(), 1'($urandom_range(0, 1))));
			end else begin
				send_item(rand_item());
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_item(mk_req(8'h10, 1'b0));
		send_item(mk_req(8'h00, 1'b1));
		send_item(mk_req(8'hFF, 1'b0));
		send_item(mk_req(8'h27, 1'b0));
	endtask

	task automatic test_security_gate();
		send_item(mk_init(1'b0, 1'b1));
		send_item(mk_req(8'h2E, 1'b0));
		send_item(mk_update(SESS_PROGRAM, 1'b0, 16'hFFFF, 8'hFF));
		send_item(mk_req(8'h2E, 1'b0));
		send_item(mk_update(SESS_KEEP, 1'b1, 16'hFFFF, 8'hFF));
		send_item(mk_req(8'h85, 1'b1));
	endtask

	task automatic test_attempt_delay();
		send_item(mk_tick(8'hFF));
		send_item(mk_update(SESS_KEEP, 1'b1, 16'd10, 8'd3));
		send_item(mk_tick(8'd6));
		send_item(mk_tick(8'd5));
		send_item(mk_tick(8'd0));
		send_item(mk_update(SESS_KEEP, 1'b0, 16'd3, 8'd0));
		send_item(mk_tick(8'd2));
	endtask

	task automatic test_session_timeout();
		// zero acts as a one-tick timeout
		write_timeout(16'd0);
		send_item(mk_init(1'b1, 1'b0));
		send_item(mk_tick(8'd0));
		send_item(mk_tick(8'd1));
		// idle left over from extended, then compared in default session
		write_timeout(16'd1000);
		send_item(mk_init(1'b1, 1'b0));
		send_item(mk_update(SESS_EXTENDED, 1'b1, 16'd0, 8'd0));
		send_item(mk_tick(8'd200));
		send_item(mk_update(SESS_DEFAULT, 1'b1, 16'd0, 8'd0));
		write_timeout(16'd100);
		send_item(mk_tick(8'd0));
	endtask

	task automatic test_backpressure();
		src_calm = 1'b1;
		long_hold = 300;
		run_random(40);
		src_calm = 1'b0;
	endtask

	task automatic test_random_phases();
		write_timeout(16'd1);
		run_random(150);
		write_timeout(16'd40);
		src_calm = 1'b1;
		sink_calm = 1'b1;
		run_random(200);
		src_calm = 1'b0;
		sink_calm = 1'b0;
		write_timeout(16'd300);
		run_random(400);
		write_timeout(16'd0);
		run_random(100);
		write_timeout(16'hFFFF);
		run_random(150);
		write_timeout(16'($urandom_range(2, 1000)));
		run_random(300);
		write_timeout(16'd60);
		run_random(160);
	endtask

	// result side: random stalls, plus a long hold when a test asks for one
	initial begin
		int r;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				hold_left = long_hold;
				long_hold = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (sink_calm) begin
				rsp_ch.ready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 78) begin
					rsp_ch.ready = 1'b1;
				end else begin
					rsp_ch.ready = 1'b0;
					hold_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 45);
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result with no request pending, expected none, got verdict %0d",
					$time, rsp_ch.verdict);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", want.verdict, rsp_ch.verdict);
				check_field("neg_code", want.neg, rsp_ch.neg_code);
				check_field("service_index", want.idx, rsp_ch.service_index);
				check_field("echo_sid", want.echo, rsp_ch.echo_sid);
				check_field("timeout_event", want.tevt, rsp_ch.timeout_event);
				check_field("system_reset", want.sreset, rsp_ch.system_reset);
				check_field("cur_session", want.sess, rsp_ch.cur_session);
				check_field("cur_security", want.sec, rsp_ch.cur_security);
				check_field("cur_attempts", want.att, rsp_ch.cur_attempts);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("diag_service_access_gate_core_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.session_timeout = 16'd0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_SERVICE;
		req_ch.service_id = 8'd0;
		req_ch.functional_addr = 1'b0;
		req_ch.time_pass = 8'd0;
		req_ch.new_session = 2'd0;
		req_ch.new_security = 1'b0;
		req_ch.new_attempt_delay = 16'd0;
		req_ch.new_attempts = 8'd0;
		req_ch.boot_flag = 1'b0;
		req_ch.unlock_flag = 1'b0;
		sess_now = SESS_DEFAULT;
		active_now = 1'b0;
		idle_now = 0;
		sec_now = 1'b0;
		routine_now = 1'b0;
		addr_now = 1'b0;
		delay_now = 0;
		tries_now = 8'd0;
		timeout_setting = TIMEOUT_RESET;
		mismatches = 0;
		items_sent = 0;
		cycle_count = 0;
		long_hold = 0;
		hold_left = 0;
		src_calm = 1'b0;
		sink_calm = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_security_gate();
		test_attempt_delay();
		test_session_timeout();
		test_backpressure();
		test_random_phases();

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("diag_service_access_gate_core_tb: clean");
		else
			$display("diag_service_access_gate_core_tb: errors");
		$finish;
	end

endmodule
